// ===== sv/pwn_pkg.sv =====
package pwn_pkg;

    localparam int W_W     = 16;
    localparam int T_W     = 22;
    localparam int P_W     = W_W + T_W;
    localparam int CNT_W   = 7;
    localparam int SLOT_W  = 6;
    localparam int STEP_W  = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;
    localparam logic [W_W-1:0]    W_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [W_W-1:0] weight_in;
        logic           is_plastic;
        logic           last_in;
    } t_in_item;

    typedef struct packed {
        logic [W_W-1:0]    weight_out;
        logic [SLOT_W-1:0] slot;
        logic              is_last;
        logic              saturated;
        logic              zero_sum;
        logic              overflow;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd;
        logic mul;
        logic prep;
        logic div;
        logic next;
        logic done;
        logic out_valid;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_slot;
        logic bypass;
    } t_stat;

endpackage

// ===== sv/pwn_if.sv =====
interface pwn_in_if;
    logic                        valid;
    logic                        ready;
    logic [pwn_pkg::W_W-1:0]     weight_in;
    logic                        is_plastic;
    logic                        last_in;

    modport source (output valid, output weight_in, output is_plastic, output last_in,
                    input ready);
    modport sink   (input valid, input weight_in, input is_plastic, input last_in,
                    output ready);
endinterface

interface pwn_out_if;
    logic                          valid;
    logic                          ready;
    logic [pwn_pkg::W_W-1:0]       weight_out;
    logic [pwn_pkg::SLOT_W-1:0]    slot;
    logic                          is_last;
    logic                          saturated;
    logic                          zero_sum;
    logic                          overflow;

    modport source (output valid, output weight_out, output slot, output is_last,
                    output saturated, output zero_sum, output overflow, input ready);
    modport sink   (input valid, input weight_out, input slot, input is_last,
                    input saturated, input zero_sum, input overflow, output ready);
endinterface

// ===== sv/plastic_weight_normalizer.sv =====
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    weight_in[16], is_plastic, last_in
// o_out     out  valid/ready    weight_out[16], slot[6], is_last, saturated,
//                               zero_sum, overflow
// i_cfg_*   in   write enable   target_total[22]
//
// While filling, one item is taken per cycle; an item with last_in starts emission.
// Each result passes through memory read, multiply, check and output when the weight
// passes unchanged or saturates, and through the 16-step restoring divider otherwise.
// No input is taken until the final result of the batch has been taken.
// A stalled output holds its result; reset (synchronous, active low) returns to filling.
module plastic_weight_normalizer #(
    parameter int MAX_SYNAPSES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [pwn_pkg::T_W-1:0]  i_cfg_data,
    pwn_in_if.sink                   i_in,
    pwn_out_if.source                o_out
);

    pwn_pkg::t_in_item  item;
    pwn_pkg::t_out_item res;
    pwn_pkg::t_cmd      cmd;
    pwn_pkg::t_stat     stat;

    assign item.weight_in  = i_in.weight_in;
    assign item.is_plastic = i_in.is_plastic;
    assign item.last_in    = i_in.last_in;

    pwn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_in),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    pwn_datapath #(
        .MAX_SYNAPSES (MAX_SYNAPSES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_res      (res)
    );

    assign o_out.weight_out = res.weight_out;
    assign o_out.slot       = res.slot;
    assign o_out.is_last    = res.is_last;
    assign o_out.saturated  = res.saturated;
    assign o_out.zero_sum   = res.zero_sum;
    assign o_out.overflow   = res.overflow;

endmodule

// ===== sv/pwn_datapath.sv =====
module pwn_datapath #(
    parameter int MAX_SYNAPSES = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pwn_pkg::T_W-1:0]   i_cfg_data,
    input  pwn_pkg::t_in_item         i_item,
    input  pwn_pkg::t_cmd             i_cmd,
    output pwn_pkg::t_stat            o_stat,
    output pwn_pkg::t_out_item        o_res
);

    localparam int AW = (MAX_SYNAPSES > 1) ? $clog2(MAX_SYNAPSES) : 1;
    localparam logic [pwn_pkg::CNT_W-1:0] DEPTH = pwn_pkg::CNT_W'(MAX_SYNAPSES);

    logic [pwn_pkg::W_W:0]      r_mem [MAX_SYNAPSES];
    logic [pwn_pkg::W_W:0]      r_rd;
    logic [pwn_pkg::P_W-1:0]    r_prod;
    logic [pwn_pkg::T_W-1:0]    r_rem;
    logic [pwn_pkg::W_W-1:0]    r_lo;
    logic                       r_sat;
    logic [pwn_pkg::SLOT_W-1:0] r_slot;
    logic [pwn_pkg::CNT_W-1:0]  r_count;
    logic [pwn_pkg::T_W-1:0]    r_sum;
    logic                       r_drop;
    logic [pwn_pkg::T_W-1:0]    r_target;

    logic                       full;
    logic                       zero;
    logic                       sat_now;
    logic                       scale;
    logic [pwn_pkg::T_W:0]      rem_sh;
    logic [pwn_pkg::T_W:0]      rem_sub;
    logic                       q_bit;

    assign full    = (r_count == DEPTH);
    assign zero    = (r_sum == '0);
    // The quotient exceeds 16 bits exactly when the upper product bits reach the sum.
    assign sat_now = (r_prod[pwn_pkg::P_W-1:pwn_pkg::W_W] >= r_sum);
    assign scale   = r_rd[0] && !zero;
    assign rem_sh  = {r_rem, r_lo[pwn_pkg::W_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_sum};
    assign q_bit   = (rem_sh >= {1'b0, r_sum});

    assign o_stat.bypass    = !scale || sat_now;
    assign o_stat.last_slot = ((pwn_pkg::CNT_W'(r_slot) + 7'd1) == r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !full) begin
            r_mem[r_count[AW-1:0]] <= {i_item.weight_in, i_item.is_plastic};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_slot[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= pwn_pkg::P_W'(r_rd[pwn_pkg::W_W:1]) * pwn_pkg::P_W'(r_target);
        end
        if (i_cmd.prep) begin
            r_sat <= scale && sat_now;
            if (!scale) begin
                r_lo <= r_rd[pwn_pkg::W_W:1];
            end else if (sat_now) begin
                r_lo <= pwn_pkg::W_MAX;
            end else begin
                r_lo  <= r_prod[pwn_pkg::W_W-1:0];
                r_rem <= r_prod[pwn_pkg::P_W-1:pwn_pkg::W_W];
            end
        end
        if (i_cmd.div) begin
            // One restoring step: the quotient bits shift in as the dividend bits shift out.
            r_lo  <= {r_lo[pwn_pkg::W_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[pwn_pkg::T_W-1:0] : rem_sh[pwn_pkg::T_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_drop   <= 1'b0;
            r_slot   <= '0;
            r_target <= '0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                if (full) begin
                    r_drop <= 1'b1;
                end else begin
                    r_count <= r_count + 7'd1;
                    if (i_item.is_plastic) begin
                        r_sum <= r_sum + pwn_pkg::T_W'(i_item.weight_in);
                    end
                end
            end
            if (i_cmd.next) begin
                r_slot <= r_slot + 6'd1;
            end
            if (i_cmd.done) begin
                r_slot  <= '0;
                r_count <= '0;
                r_sum   <= '0;
                r_drop  <= 1'b0;
            end
        end
    end

    assign o_res.weight_out = r_lo;
    assign o_res.slot       = r_slot;
    assign o_res.is_last    = o_stat.last_slot;
    assign o_res.saturated  = r_sat;
    assign o_res.zero_sum   = zero;
    assign o_res.overflow   = r_drop;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH)
        else $error("item count exceeds the buffer depth");

    a_slot_in_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_valid |-> (pwn_pkg::CNT_W'(r_slot) < r_count))
        else $error("result slot outside the buffered batch");

    a_batch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.done |=> (r_count == '0) && (r_sum == '0) && !r_drop && (r_slot == '0))
        else $error("batch state not cleared after the final result");

endmodule

// ===== sv/pwn_ctrl.sv =====
module pwn_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    input  logic            i_out_ready,
    input  pwn_pkg::t_stat  i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output pwn_pkg::t_cmd   o_cmd
);

    typedef enum logic [5:0] {
        ST_FILL = 6'b000001,
        ST_READ = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_PREP = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic [pwn_pkg::STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            ST_FILL: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_step     = '0;
                n_state    = i_stat.bypass ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                n_step    = r_step + 4'd1;
                if (r_step == pwn_pkg::LAST_STEP) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_cmd.out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.last_slot) begin
                        o_cmd.done = 1'b1;
                        n_state    = ST_FILL;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state    = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_FILL);
    assign o_out_valid = (r_state == ST_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_div_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) && (n_state == ST_OUT) |-> (r_step == pwn_pkg::LAST_STEP))
        else $error("division left before all quotient bits were formed");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result is being offered");

    a_done_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |=> (r_state == ST_FILL))
        else $error("controller did not return to filling after the batch");

endmodule

// ===== test/plastic_weight_normalizer_test.sv =====
module plastic_weight_normalizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH         = 64;
    localparam int RANDOM_ITEMS  = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 30;
    localparam int QUIET_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [pwn_pkg::T_W-1:0] TARGET_MAX = 22'h3FFFFF;

    // Keeps its own copy of the synapse buffer and the target, and predicts the
    // normalized weights of a batch when its final item is taken.
    class norm_scoreboard;
        logic [pwn_pkg::W_W-1:0] weights [DEPTH];
        logic                    marks [DEPTH];
        logic [pwn_pkg::T_W-1:0] plastic_total;
        logic [pwn_pkg::T_W-1:0] target;
        int                      count;
        logic                    dropped;
        pwn_pkg::t_out_item      due_results [$];
        int                      mismatches;

        function new();
            plastic_total = '0;
            target        = '0;
            count         = 0;
            dropped       = 1'b0;
            mismatches    = 0;
        endfunction

        function void set_target(logic [pwn_pkg::T_W-1:0] value);
            target = value;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void note_synapse(pwn_pkg::t_in_item it);
            logic [pwn_pkg::P_W-1:0] product;
            logic [pwn_pkg::P_W-1:0] quotient;
            logic                    zero;
            pwn_pkg::t_out_item      res;
            if (count < DEPTH) begin
                weights[count] = it.weight_in;
                marks[count]   = it.is_plastic;
                if (it.is_plastic) begin
                    plastic_total = plastic_total + pwn_pkg::T_W'(it.weight_in);
                end
                count++;
            end else begin
                dropped = 1'b1;
            end
            if (!it.last_in) begin
                return;
            end
            zero = (plastic_total == '0);
            for (int k = 0; k < count; k++) begin
                res.weight_out = weights[k];
                res.saturated  = 1'b0;
                if (marks[k] && !zero) begin
                    product  = pwn_pkg::P_W'(weights[k]) * pwn_pkg::P_W'(target);
                    quotient = product / pwn_pkg::P_W'(plastic_total);
                    if (quotient > pwn_pkg::P_W'(pwn_pkg::W_MAX)) begin
                        res.weight_out = pwn_pkg::W_MAX;
                        res.saturated  = 1'b1;
                    end else begin
                        res.weight_out = quotient[pwn_pkg::W_W-1:0];
                    end
                end
                res.slot     = pwn_pkg::SLOT_W'(k);
                res.is_last  = (k == count - 1);
                res.zero_sum = zero;
                res.overflow = dropped;
                due_results.push_back(res);
            end
            plastic_total = '0;
            count         = 0;
            dropped       = 1'b0;
        endfunction

        function void report_error(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%s", msg);
            end
        endfunction

        function void check_result(pwn_pkg::t_out_item got);
            pwn_pkg::t_out_item want;
            if (due_results.size() == 0) begin
                report_error($sformatf("unexpected result: slot %0d weight %h",
                                       got.slot, got.weight_out));
                return;
            end
            want = due_results.pop_front();
            if (got.weight_out !== want.weight_out || got.slot !== want.slot ||
                got.is_last !== want.is_last || got.saturated !== want.saturated ||
                got.zero_sum !== want.zero_sum || got.overflow !== want.overflow) begin
                report_error($sformatf({"result mismatch: expected w=%h slot=%0d last=%b ",
                                        "sat=%b zero=%b ovf=%b, got w=%h slot=%0d last=%b ",
                                        "sat=%b zero=%b ovf=%b"},
                                       want.weight_out, want.slot, want.is_last,
                                       want.saturated, want.zero_sum, want.overflow,
                                       got.weight_out, got.slot, got.is_last,
                                       got.saturated, got.zero_sum, got.overflow));
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [pwn_pkg::T_W-1:0] i_cfg_data;

    pwn_in_if  in_ch ();
    pwn_out_if out_ch ();

    norm_scoreboard sb = new();

    int unsigned quiet_cycles = 0;
    int          items_sent   = 0;
    bit          in_calm      = 1'b0;
    bit          out_calm     = 1'b0;

    plastic_weight_normalizer #(
        .MAX_SYNAPSES(DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly no stall or a short one, now and then a long one.
    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [pwn_pkg::W_W-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                return '0;
            end
            1: begin
                return pwn_pkg::W_MAX;
            end
            2, 3, 4: begin
                return pwn_pkg::W_W'($urandom_range(0, 1023));
            end
            default: begin
                return pwn_pkg::W_W'($urandom_range(0, 65535));
            end
        endcase
    endfunction

    function automatic logic [pwn_pkg::T_W-1:0] pick_target();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return TARGET_MAX;
        end else if (r < 4) begin
            return pwn_pkg::T_W'($urandom_range(1, 65535));
        end else if (r < 7) begin
            return pwn_pkg::T_W'($urandom_range(32'h10000, 32'h80000));
        end
        return pwn_pkg::T_W'($urandom_range(0, 4194303));
    endfunction

    task automatic send_synapse(input logic [pwn_pkg::W_W-1:0] w, input logic plastic,
                                input logic last);
        pwn_pkg::t_in_item it;
        int                gap;
        it  = '{weight_in: w, is_plastic: plastic, last_in: last};
        gap = in_calm ? 0 : stall_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.weight_in  <= w;
        in_ch.is_plastic <= plastic;
        in_ch.last_in    <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_synapse(it);
        items_sent++;
    endtask

    // The target may only change once the previous batch has fully drained.
    task automatic program_target(input logic [pwn_pkg::T_W-1:0] value);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_target(value);
    endtask

    task automatic send_random_batch(input int n);
        bit                      no_plastic_sum;
        logic                    plastic;
        logic [pwn_pkg::W_W-1:0] w;
        no_plastic_sum = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < n; i++) begin
            plastic = 1'($urandom_range(0, 1));
            w       = pick_weight();
            if (no_plastic_sum && plastic) begin
                w = '0;
            end
            send_synapse(w, plastic, i == n - 1);
        end
    endtask

    initial begin : ready_gen
        int hold;
        int s;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                s = out_calm ? 0 : stall_len();
                if (s == 0) begin
                    out_ch.ready <= 1'b1;
                    hold = out_calm ? 0 : $urandom_range(0, 5);
                end else begin
                    out_ch.ready <= 1'b0;
                    hold = s - 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result('{out_ch.weight_out, out_ch.slot, out_ch.is_last,
                              out_ch.saturated, out_ch.zero_sum, out_ch.overflow});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("[plastic_weight_normalizer] ERROR");
        $finish;
    end

    initial begin : stimulus
        int directed_items;
        int batch_no;
        int n;
        int r;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_data       <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.weight_in  <= '0;
        in_ch.is_plastic <= 1'b0;
        in_ch.last_in    <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Largest target: plastic weights saturate, zero stays zero.
        program_target(TARGET_MAX);
        send_synapse(16'hFFFF, 1'b1, 1'b0);
        send_synapse(16'h0000, 1'b1, 1'b0);
        send_synapse(16'h0001, 1'b0, 1'b0);
        send_synapse(16'hFFFF, 1'b0, 1'b1);
        send_synapse(16'hFFFF, 1'b1, 1'b1);
        // No plastic weight adds to the first sum, so that batch passes unchanged; the lone weight after it saturates.
        send_synapse(16'h1234, 1'b0, 1'b0);
        send_synapse(16'h0000, 1'b1, 1'b0);
        send_synapse(16'hABCD, 1'b0, 1'b1);
        send_synapse(16'h0001, 1'b1, 1'b1);

        // A zero target drives every plastic weight to zero.
        program_target('0);
        send_synapse(16'h8000, 1'b1, 1'b0);
        send_synapse(16'h7FFF, 1'b1, 1'b0);
        send_synapse(16'h5555, 1'b0, 1'b0);
        send_synapse(16'hAAAA, 1'b1, 1'b1);

        // Exact scaling without saturation.
        program_target(22'h010000);
        send_synapse(16'h0100, 1'b1, 1'b0);
        send_synapse(16'h0300, 1'b1, 1'b0);
        send_synapse(16'h0200, 1'b0, 1'b1);
        send_synapse(16'hFFFF, 1'b0, 1'b1);

        directed_items = items_sent;
        batch_no = 0;
        while (items_sent - directed_items < RANDOM_ITEMS) begin
            program_target(pick_target());
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 5)) begin
                if (items_sent - directed_items >= RANDOM_ITEMS) begin
                    break;
                end
                r = $urandom_range(0, 9);
                if (batch_no == 1) begin
                    n = DEPTH;
                end else if (batch_no == 4) begin
                    // More items than the buffer holds; every item past the depth is dropped,
                    // and the final one, though dropped, still closes the batch.
                    n = $urandom_range(DEPTH + 1, DEPTH + 6);
                end else if (r < 8) begin
                    n = $urandom_range(1, 8);
                end else begin
                    n = $urandom_range(9, 24);
                end
                send_random_batch(n);
                batch_no++;
            end
        end

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[plastic_weight_normalizer] OK");
        end else begin
            $display("[plastic_weight_normalizer] ERROR");
        end
        $finish;
    end

endmodule
